// ===== design/ssd_pkg.sv =====
// Package for the shift-subtract unsigned divider.
// Holds the data width, the per-cell data record and the cell step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int NUM_CELLS  = DATA_WIDTH;

	// Partial division carried from one cell to the next
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;  // partial remainder, below den unless den is zero
		logic [DATA_WIDTH-1:0] num;  // dividend bits not yet taken in, MSB first
		logic [DATA_WIDTH-1:0] den;  // divisor
		logic [DATA_WIDTH-1:0] quo;  // quotient bits so far, shifted in at the LSB
		logic                  dz;   // divisor was zero
	} ssd_data_t;

	// One restoring step: take in the next dividend bit, subtract if it fits
	function automatic ssd_data_t ssd_step(input ssd_data_t d);
		logic [DATA_WIDTH:0] sh;
		logic [DATA_WIDTH:0] diff;
		logic                fits;
		ssd_data_t           r;
		sh   = {d.rem, d.num[DATA_WIDTH-1]};
		diff = sh - {1'b0, d.den};
		fits = (sh >= {1'b0, d.den});
		r     = d;
		r.rem = fits ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
		r.num = {d.num[DATA_WIDTH-2:0], 1'b0};
		r.quo = {d.quo[DATA_WIDTH-2:0], fits};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/ssd_cell.sv =====
// One divider cell: a restoring step followed by its own register stage.
// Depends on ssd_pkg for the data record and the step function.
`timescale 1ns / 1ps
`default_nettype none

module ssd_cell
	import ssd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      up_valid,
	output logic           up_ready,
	input  wire ssd_data_t up_data,
	output logic           dn_valid,
	input  wire logic      dn_ready,
	output ssd_data_t      dn_data
);

	logic      valid_q;
	ssd_data_t data_q;

	// Cell can load when empty or when its content moves on this cycle
	assign up_ready = !valid_q || dn_ready;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Step result register
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= ssd_step(up_data);
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

`default_nettype wire

// ===== design/shift_subtract_unsigned_divider_top.sv =====
// Top level of the shift-subtract unsigned divider: a chain of ssd_cell stages.
// Depends on ssd_pkg and ssd_cell.
//
// Divides a 32-bit unsigned dividend by a 32-bit unsigned divisor and returns the
// truncated quotient. The chain has one cell per quotient bit, each doing one
// compare-and-subtract on the partial remainder and registering it. The input edge
// loads the first cell, and a result passes through the register of every cell in
// order before it is valid at the output; one transaction can enter every cycle
// while the output drains or a bubble is left. Each cell holds its own valid bit, so bubbles
// close up while the output is stalled and input keeps being taken until the
// chain is full. A zero divisor gives an all-ones quotient with divide_by_zero set.
`timescale 1ns / 1ps
`default_nettype none

module shift_subtract_unsigned_divider_top
	import ssd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      quotient,
	output logic                       divide_by_zero
);

	// Links between cells; link 0 is the input, link NUM_CELLS the output
	logic      link_valid [NUM_CELLS+1];
	logic      link_ready [NUM_CELLS+1];
	ssd_data_t link_data  [NUM_CELLS+1];

	// Input record: empty remainder and quotient
	always_comb begin
		link_data[0].rem = '0;
		link_data[0].num = dividend;
		link_data[0].den = divisor;
		link_data[0].quo = '0;
		link_data[0].dz  = (divisor == '0);
	end
	assign link_valid[0] = in_valid;
	assign in_ready      = link_ready[0];

	// Cell chain, one per quotient bit
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		ssd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up_data  (link_data[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn_data  (link_data[i+1])
		);
	end

	// Output side; a zero divisor already yields all ones from the steps
	assign link_ready[NUM_CELLS] = out_ready;
	assign out_valid      = link_valid[NUM_CELLS];
	assign quotient       = link_data[NUM_CELLS].quo;
	assign divide_by_zero = link_data[NUM_CELLS].dz;

endmodule

`default_nettype wire

// ===== design/ssd_checker.sv =====
// Port-level checker for the shift-subtract unsigned divider, with its bind.
// Depends on ssd_pkg and shift_subtract_unsigned_divider_top.
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker
	import ssd_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic [DATA_WIDTH-1:0] dividend,
	input wire logic [DATA_WIDTH-1:0] divisor,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [DATA_WIDTH-1:0] quotient,
	input wire logic                  divide_by_zero
);

	// Stalled output transaction stays valid
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	// Stalled output payload stays put
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(quotient) && $stable(divide_by_zero))
		else $error("output payload changed while stalled");

	// Zero divisor always comes out as an all-ones quotient
	a_dz_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> quotient == {DATA_WIDTH{1'b1}})
		else $error("divide by zero without all-ones quotient");

	// A draining output lets the whole chain move, so input is taken
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind shift_subtract_unsigned_divider_top ssd_checker u_ssd_checker (.*);

`default_nettype wire
